// ===== design/lqrgs_pkg.sv =====
// Package with shared types, constants and fitted coefficients of the gain scheduler.
package lqrgs_pkg;

    // Default sizes of the coefficient table.
    localparam int DEF_GAINS = 6;
    localparam int DEF_TERMS = 5;

    // Gains reported per wheel on the result channel.
    localparam int OUT_GAINS = 6;

    // Shape of the fitted coefficient set.
    localparam int FIT_GAINS = 6;
    localparam int FIT_TERMS = 5;

    // Field widths.
    localparam int IDX_W   = 6;
    localparam int COEF_W  = 24;
    localparam int ANGLE_W = 16;
    localparam int PROD_W  = COEF_W + ANGLE_W;

    // Saturation limits of a Q8.16 value.
    localparam logic signed [COEF_W-1:0] SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [COEF_W-1:0] SAT_MIN = -24'sh800000;

    // Command codes.
    typedef enum logic {
        CMD_COMPUTE = 1'b0,
        CMD_WRITE   = 1'b1
    } cmd_t;

    // Input item.
    typedef struct packed {
        logic                      command;
        logic [IDX_W-1:0]          coef_index;
        logic signed [COEF_W-1:0]  coef_value;
        logic signed [ANGLE_W-1:0] left_angle;
        logic signed [ANGLE_W-1:0] right_angle;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic signed [COEF_W-1:0] left_gain_0;
        logic signed [COEF_W-1:0] left_gain_1;
        logic signed [COEF_W-1:0] left_gain_2;
        logic signed [COEF_W-1:0] left_gain_3;
        logic signed [COEF_W-1:0] left_gain_4;
        logic signed [COEF_W-1:0] left_gain_5;
        logic signed [COEF_W-1:0] right_gain_0;
        logic signed [COEF_W-1:0] right_gain_1;
        logic signed [COEF_W-1:0] right_gain_2;
        logic signed [COEF_W-1:0] right_gain_3;
        logic signed [COEF_W-1:0] right_gain_4;
        logic signed [COEF_W-1:0] right_gain_5;
    } out_item_t;

    // Step strobes from the sequencer to every lane.
    typedef struct packed {
        logic load;
        logic mul;
        logic add;
    } lane_ctl_t;

    // Coefficient write request broadcast to the lanes.
    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         idx;
        logic signed [COEF_W-1:0] value;
    } coef_wr_t;

    // Fitted coefficients in Q8.16, indexed [wheel][gain][term], term 0 is the fourth power.
    localparam logic signed [COEF_W-1:0] FIT_COEF [2][FIT_GAINS][FIT_TERMS] = '{
        '{
            '{24'sd0, 24'sd0, 24'sd0, 24'sd0, -24'sd179478},
            '{-24'sd24438, 24'sd41839, -24'sd26636, 24'sd5768, -24'sd135967},
            '{24'sd12493, -24'sd24856, 24'sd54753, -24'sd3207, -24'sd470146},
            '{-24'sd3657, 24'sd2766, 24'sd15056, 24'sd405, -24'sd50909},
            '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd179478},
            '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd19005}
        },
        '{
            '{24'sd0, 24'sd0, 24'sd0, 24'sd0, -24'sd179478},
            '{-24'sd24438, 24'sd41839, -24'sd26636, 24'sd5768, -24'sd135967},
            '{24'sd12493, -24'sd24856, 24'sd54753, -24'sd3207, -24'sd470146},
            '{-24'sd3657, 24'sd2766, 24'sd15056, 24'sd405, -24'sd50909},
            '{24'sd0, 24'sd0, 24'sd0, 24'sd0, -24'sd179478},
            '{24'sd0, 24'sd0, 24'sd0, 24'sd0, -24'sd19005}
        }
    };

    // Reset value of one coefficient given wheel, gain and power; zero where no fit exists.
    function automatic logic signed [COEF_W-1:0] fit_coef(input int wheel, input int gain,
                                                          input int power);
        logic signed [COEF_W-1:0] value;
        value = '0;
        if (gain < FIT_GAINS && power < FIT_TERMS) begin
            value = FIT_COEF[wheel][gain][FIT_TERMS-1-power];
        end
        return value;
    endfunction

endpackage

// ===== design/lqrgs_lane.sv =====
// One gain lane: its coefficient slice and a Horner evaluator with a registered multiplier.
module lqrgs_lane
    import lqrgs_pkg::*;
#(
    parameter int TERMS  = DEF_TERMS,
    parameter int BASE   = 0,
    parameter int WHEEL  = 0,
    parameter int GAIN   = 0,
    parameter int TERM_W = $clog2(TERMS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lane_ctl_t                 ctl,
    input  logic [TERM_W-1:0]         term,
    input  logic signed [ANGLE_W-1:0] x,
    input  coef_wr_t                  wr,
    output logic signed [COEF_W-1:0]  gain
);

    localparam int RND_W = PROD_W - 13;
    localparam int SUM_W = RND_W + 1;

    logic signed [COEF_W-1:0] coef_reg [TERMS];
    logic signed [COEF_W-1:0] acc_reg;
    logic signed [COEF_W-1:0] acc_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  sum;

    // Coefficient slice: reset to the fitted values, rewritten by matching table index.
    for (genvar t = 0; t < TERMS; t++) begin : g_coef
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                coef_reg[t] <= fit_coef(WHEEL, GAIN, TERMS - 1 - t);
            end else if (wr.en && int'(wr.idx) == BASE + t) begin
                coef_reg[t] <= wr.value;
            end
        end
    end

    // Horner step: round the product to Q8.16, add the next coefficient and saturate.
    always_comb begin
        prod_next = acc_reg * x;
        rnd       = RND_W'((prod_reg + PROD_W'(4096)) >>> 13);
        sum       = SUM_W'(rnd) + SUM_W'(coef_reg[term]);
        if (sum > SUM_W'(SAT_MAX)) begin
            acc_next = SAT_MAX;
        end else if (sum < SUM_W'(SAT_MIN)) begin
            acc_next = SAT_MIN;
        end else begin
            acc_next = COEF_W'(sum);
        end
    end

    // Accumulator and product registers.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            acc_reg <= coef_reg[0];
        end else if (ctl.add) begin
            acc_reg <= acc_next;
        end
        if (ctl.mul) begin
            prod_reg <= prod_next;
        end
    end

    assign gain = acc_reg;

endmodule

// ===== design/lqrgs_merge.sv =====
// Merging stage: gathers the lane gains into a result and holds it in the output register.
module lqrgs_merge
    import lqrgs_pkg::*;
#(
    parameter int GAINS = DEF_GAINS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  logic [2*GAINS-1:0][COEF_W-1:0]    gains,
    input  logic                              m_ready,
    output logic                              m_valid,
    output out_item_t                         m_data,
    output logic                              out_free
);

    logic [1:0][OUT_GAINS-1:0][COEF_W-1:0] sel;
    out_item_t                             data_reg;
    out_item_t                             data_next;
    logic                                  valid_reg;

    // Reported gains come from the lanes; gains past the lane count read as zero.
    for (genvar w = 0; w < 2; w++) begin : g_wheel
        for (genvar g = 0; g < OUT_GAINS; g++) begin : g_gain
            if (g < GAINS) begin : g_lane
                assign sel[w][g] = gains[w*GAINS + g];
            end else begin : g_zero
                assign sel[w][g] = '0;
            end
        end
    end

    // Pack the result item.
    always_comb begin
        data_next.left_gain_0  = sel[0][0];
        data_next.left_gain_1  = sel[0][1];
        data_next.left_gain_2  = sel[0][2];
        data_next.left_gain_3  = sel[0][3];
        data_next.left_gain_4  = sel[0][4];
        data_next.left_gain_5  = sel[0][5];
        data_next.right_gain_0 = sel[1][0];
        data_next.right_gain_1 = sel[1][1];
        data_next.right_gain_2 = sel[1][2];
        data_next.right_gain_3 = sel[1][3];
        data_next.right_gain_4 = sel[1][4];
        data_next.right_gain_5 = sel[1][5];
    end

    // Output register: loaded when free, emptied by a result transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

endmodule

// ===== design/lqr_gain_polynomial_schedule.sv =====
// Top level of the gain scheduler: sequencer, gain lanes and merging stage.
//
//   Channel  Ports                       Moves
//   input    s_valid s_ready s_data      compute or coefficient-write item (in_item_t)
//   result   m_valid m_ready m_data      twelve saturated gains (out_item_t)
//
// A compute transfer runs the Horner loop: each step is a multiply state and a round-add-saturate
// state in every lane, and no new item is taken while the loop runs.
// All 2*GAINS_PER_WHEEL lanes run in parallel; the next item is taken in the cycle the
// finished gains move into the output register.
// A coefficient write gives no result.
// After reset the table holds the fitted values at once; no clearing pass is needed.
// A stalled result waits in the output register; the lanes hold their gains until it frees.
module lqr_gain_polynomial_schedule
    import lqrgs_pkg::*;
#(
    parameter int GAINS_PER_WHEEL = DEF_GAINS,
    parameter int TERMS_PER_GAIN  = DEF_TERMS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int LANES  = 2 * GAINS_PER_WHEEL;
    localparam int TERM_W = $clog2(TERMS_PER_GAIN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [TERM_W-1:0]         term_reg;
    logic [TERM_W-1:0]         term_next;
    logic signed [ANGLE_W-1:0] x_reg [2];
    logic                      accept;
    logic                      take_compute;
    logic                      out_free;
    logic                      merge_load;
    lane_ctl_t                 ctl;
    coef_wr_t                  wr;
    logic [LANES-1:0][COEF_W-1:0] gains;

    // Handshake and lane strobes.
    always_comb begin
        s_ready      = (state_reg == ST_IDLE) || (state_reg == ST_DONE && out_free);
        accept       = s_valid && s_ready;
        take_compute = accept && s_data.command == CMD_COMPUTE;
        merge_load   = (state_reg == ST_DONE) && out_free;
        ctl.load     = take_compute;
        ctl.mul      = (state_reg == ST_MUL);
        ctl.add      = (state_reg == ST_ADD);
        wr.en        = accept && s_data.command == CMD_WRITE;
        wr.idx       = s_data.coef_index;
        wr.value     = s_data.coef_value;
    end

    // Sequencer next state: alternate multiply and add until the constant term is added.
    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_compute) begin
                    state_next = ST_MUL;
                    term_next  = TERM_W'(1);
                end
            end
            ST_MUL: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (term_reg == TERM_W'(TERMS_PER_GAIN - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                    term_next  = term_reg + TERM_W'(1);
                end
            end
            ST_DONE: begin
                if (take_compute) begin
                    state_next = ST_MUL;
                    term_next  = TERM_W'(1);
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state, term counter and latched angles.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            term_reg  <= '0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
        if (take_compute) begin
            x_reg[0] <= s_data.left_angle;
            x_reg[1] <= s_data.right_angle;
        end
    end

    // One lane per gain of each wheel.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        lqrgs_lane #(
            .TERMS  (TERMS_PER_GAIN),
            .BASE   (l * TERMS_PER_GAIN),
            .WHEEL  (l / GAINS_PER_WHEEL),
            .GAIN   (l % GAINS_PER_WHEEL),
            .TERM_W (TERM_W)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .term    (term_reg),
            .x       (x_reg[l / GAINS_PER_WHEEL]),
            .wr      (wr),
            .gain    (gains[l])
        );
    end

    // Result assembly and output register.
    lqrgs_merge #(
        .GAINS (GAINS_PER_WHEEL)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (merge_load),
        .gains    (gains),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_data   (m_data),
        .out_free (out_free)
    );

`ifndef NO_ASSERTIONS
    // A compute transfer always starts the multiply step.
    a_compute_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        take_compute |=> state_reg == ST_MUL)
        else $error("compute transfer did not start the Horner loop");

    // A new result appears only after the lanes have finished.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised without finished lanes");

    // A coefficient write taken while idle never produces a result.
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && state_reg == ST_IDLE) |=> !$rose(m_valid))
        else $error("coefficient write produced a result");

    // The term counter stays within the polynomial during the add step.
    a_term_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADD |-> term_reg <= TERM_W'(TERMS_PER_GAIN - 1))
        else $error("term counter out of range");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the gain scheduler: directed and random items, scoreboard check.
module tb
    import lqrgs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_GAINS      = DEF_GAINS;
    localparam int N_TERMS      = DEF_TERMS;
    localparam int TABLE_SIZE   = 2 * N_GAINS * N_TERMS;
    localparam int ITEM_CYCLES  = 2 * (N_TERMS - 1) + 1;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 400;
    localparam int WRITE_PCT    = 15;
    localparam longint GAIN_MAX = 8388607;
    localparam longint GAIN_MIN = -8388608;
    localparam realtime RUN_LIMIT = 1000us;

    // Fitted coefficients in units of 1e-5, [wheel][gain][term], term 0 is the fourth power.
    localparam int FIT_UNITS [2*FIT_GAINS*FIT_TERMS] = '{
        0, 0, 0, 0, -273861,
        -37290, 63841, -40643, 8801, -207469,
        19063, -37928, 83546, -4894, -717386,
        -5580, 4221, 22974, 618, -77681,
        0, 0, 0, 0, 273861,
        0, 0, 0, 0, 29000,
        0, 0, 0, 0, -273861,
        -37290, 63841, -40643, 8801, -207469,
        19063, -37928, 83546, -4894, -717386,
        -5580, 4221, 22974, 618, -77681,
        0, 0, 0, 0, -273861,
        0, 0, 0, 0, -29000
    };

    typedef enum {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC
    } ready_mode_t;

    // Tracks the coefficient table and the gains that are still to come out.
    class gain_scoreboard_t;
        logic signed [COEF_W-1:0] coef_table [TABLE_SIZE];
        out_item_t pending_gains [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                coef_table[i] = fitted_value(i);
            end
        endfunction

        // Reset value of one table slot, rounded from the fitted decimal value to Q8.16.
        function logic signed [COEF_W-1:0] fitted_value(int idx);
            int wheel, gain, term, power, units;
            longint mag;
            wheel = idx / (N_GAINS * N_TERMS);
            gain  = (idx % (N_GAINS * N_TERMS)) / N_TERMS;
            term  = idx % N_TERMS;
            power = N_TERMS - 1 - term;
            if (gain >= FIT_GAINS || power >= FIT_TERMS) begin
                return '0;
            end
            units = FIT_UNITS[(wheel * FIT_GAINS + gain) * FIT_TERMS + (FIT_TERMS - 1 - power)];
            mag = units < 0 ? -longint'(units) : longint'(units);
            mag = (mag * 65536 + 50000) / 100000;
            return units < 0 ? COEF_W'(-mag) : COEF_W'(mag);
        endfunction

        // Horner evaluation of one gain with round-half-up and saturation at every step.
        function logic signed [COEF_W-1:0] horner_gain(int base, logic signed [ANGLE_W-1:0] angle);
            longint acc;
            longint prod;
            acc = coef_table[base];
            for (int k = 1; k < N_TERMS; k++) begin
                prod = (acc * longint'(angle) + 4096) >>> 13;
                acc = prod + longint'(coef_table[base + k]);
                if (acc > GAIN_MAX) begin
                    acc = GAIN_MAX;
                end else if (acc < GAIN_MIN) begin
                    acc = GAIN_MIN;
                end
            end
            return acc[COEF_W-1:0];
        endfunction

        // Twelve gains for one pair of leg angles.
        function out_item_t schedule_gains(in_item_t item);
            logic [2*OUT_GAINS*COEF_W-1:0] bits;
            logic signed [ANGLE_W-1:0] angle;
            bits = '0;
            for (int w = 0; w < 2; w++) begin
                angle = (w == 0) ? item.left_angle : item.right_angle;
                for (int g = 0; g < OUT_GAINS && g < N_GAINS; g++) begin
                    bits[(2*OUT_GAINS-1-(w*OUT_GAINS+g))*COEF_W +: COEF_W] =
                        horner_gain((w * N_GAINS + g) * N_TERMS, angle);
                end
            end
            return out_item_t'(bits);
        endfunction

        // An accepted input transfer either rewrites a coefficient or expects a result.
        function void note_transfer(in_item_t item);
            if (item.command == CMD_WRITE) begin
                if (item.coef_index < TABLE_SIZE) begin
                    coef_table[item.coef_index] = item.coef_value;
                end
            end else begin
                pending_gains.push_back(schedule_gains(item));
            end
        endfunction

        // Compare one result transfer, field by field, with the oldest expectation.
        function void check_gains(out_item_t got);
            out_item_t want;
            logic [2*OUT_GAINS*COEF_W-1:0] want_bits, got_bits;
            logic signed [COEF_W-1:0] want_f, got_f;
            if (pending_gains.size() == 0) begin
                $display("%0t: result transfer with no gains expected, got %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_gains.pop_front();
            want_bits = want;
            got_bits = got;
            for (int i = 0; i < 2 * OUT_GAINS; i++) begin
                want_f = want_bits[(2*OUT_GAINS-1-i)*COEF_W +: COEF_W];
                got_f  = got_bits[(2*OUT_GAINS-1-i)*COEF_W +: COEF_W];
                if (want_f !== got_f) begin
                    $display("%0t: %s_gain_%0d expected %0d, got %0d", $time,
                             i < OUT_GAINS ? "left" : "right", i % OUT_GAINS, want_f, got_f);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic      hold_req;

    gain_scoreboard_t sb;

    lqr_gain_polynomial_schedule #(
        .GAINS_PER_WHEEL(N_GAINS),
        .TERMS_PER_GAIN (N_TERMS)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Clock, 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT);
        $display("lqr_gain_polynomial_schedule test failed");
        $finish;
    end

    // Offer one item and hold it until the transfer happens.
    task automatic push_item(input in_item_t item);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Sender gap of the given number of cycles.
    task automatic idle_sender(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Wait at falling edges so that the monitor has seen every rising edge before.
    task automatic wait_for_results();
        @(negedge aclk);
        while (sb.pending_gains.size() != 0) @(negedge aclk);
    endtask

    function automatic in_item_t make_item(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                                           input logic [COEF_W-1:0] value,
                                           input logic [ANGLE_W-1:0] left,
                                           input logic [ANGLE_W-1:0] right);
        in_item_t item;
        item.command     = cmd;
        item.coef_index  = idx;
        item.coef_value  = value;
        item.left_angle  = left;
        item.right_angle = right;
        return item;
    endfunction

    // Compute item; the coefficient fields carry random junk.
    function automatic in_item_t compute_item(input logic [ANGLE_W-1:0] left,
                                              input logic [ANGLE_W-1:0] right);
        return make_item(CMD_COMPUTE, IDX_W'($urandom), COEF_W'($urandom), left, right);
    endfunction

    // Write item; the angle fields carry random junk.
    function automatic in_item_t write_item(input logic [IDX_W-1:0] idx,
                                            input logic [COEF_W-1:0] value);
        return make_item(CMD_WRITE, idx, value, ANGLE_W'($urandom), ANGLE_W'($urandom));
    endfunction

    // Realistic leg angles half the time, with full-range values and the extremes mixed in.
    function automatic logic [ANGLE_W-1:0] random_angle();
        case ($urandom_range(0, 3))
            0, 1:    return ANGLE_W'($urandom_range(0, 19660)) - ANGLE_W'(9830);
            2:       return ANGLE_W'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // Random item: mostly computes; writes put in wild, small or fitted coefficients.
    function automatic in_item_t random_item();
        in_item_t item;
        item.command    = ($urandom_range(0, 99) < WRITE_PCT) ? CMD_WRITE : CMD_COMPUTE;
        item.coef_index = IDX_W'($urandom_range(0, 63));
        case ($urandom_range(0, 2))
            0:       item.coef_value = COEF_W'($urandom);
            1:       item.coef_value = COEF_W'($urandom_range(0, 262143)) - COEF_W'(131072);
            default: item.coef_value = (item.coef_index < TABLE_SIZE) ?
                                       sb.fitted_value(item.coef_index) : COEF_W'($urandom);
        endcase
        item.left_angle  = random_angle();
        item.right_angle = random_angle();
        return item;
    endfunction

    // Monitor of both channels and the receiver's ready pattern.
    initial begin : result_side
        ready_mode_t mode;
        int unsigned run_left;
        int unsigned hold_left;
        int unsigned tick;
        mode = RDY_ALWAYS;
        run_left = 0;
        hold_left = 0;
        tick = 0;
        m_ready = 1'b0;
        forever begin
            // Results are checked before inputs are noted, so ordering within an edge is fixed.
            @(posedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    sb.check_gains(m_data);
                end
                if (s_valid && s_ready) begin
                    sb.note_transfer(s_data);
                end
            end
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (run_left == 0) begin
                mode = ready_mode_t'($urandom_range(0, 2));
                run_left = $urandom_range(20, 200);
            end
            run_left--;
            tick++;
            // A long hold-off overrides the pattern so that the block backs up.
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    RDY_ALWAYS: m_ready <= 1'b1;
                    RDY_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                    default:    m_ready <= (tick % 7) < 3;
                endcase
            end
        end
    end

    // Stimulus.
    initial begin : stimulus
        in_item_t item;
        int unsigned sent;
        bit held;
        bit drained;
        sb = new();
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        hold_req = 1'b0;
        sent = 0;
        held = 1'b0;
        drained = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fitted table at zero, extreme and unit angles.
        push_item(compute_item(16'h0000, 16'h0000));
        push_item(compute_item(16'h7FFF, 16'h8000));
        push_item(compute_item(16'h8000, 16'h7FFF));
        push_item(compute_item(16'h2000, 16'hE000));
        push_item(make_item(CMD_COMPUTE, 6'h3F, 24'hFFFFFF, 16'h0001, 16'hFFFF));

        // Writes beyond the table must be ignored.
        push_item(write_item(6'd63, 24'h800000));
        push_item(write_item(6'd60, 24'h7FFFFF));
        push_item(compute_item(16'h2000, 16'h2000));

        // Extreme coefficients drive the Horner steps into both saturation limits.
        push_item(write_item(6'd0, 24'h7FFFFF));
        push_item(write_item(6'd1, 24'h7FFFFF));
        push_item(write_item(6'd30, 24'h800000));
        push_item(write_item(6'd34, 24'h7FFFFF));
        push_item(compute_item(16'h7FFF, 16'h8000));
        push_item(compute_item(16'h8000, 16'h7FFF));
        push_item(make_item(CMD_WRITE, 6'd59, 24'h800000, 16'hFFFF, 16'hFFFF));
        push_item(compute_item(16'h7FFF, 16'h7FFF));

        // Put the fitted values back.
        push_item(write_item(6'd0, sb.fitted_value(0)));
        push_item(write_item(6'd1, sb.fitted_value(1)));
        push_item(write_item(6'd30, sb.fitted_value(30)));
        push_item(write_item(6'd34, sb.fitted_value(34)));
        push_item(write_item(6'd59, sb.fitted_value(59)));
        push_item(compute_item(16'h1000, 16'hF000));
        idle_sender(1);
        wait_for_results();

        // Random bursts with random gaps.
        while (sent < RANDOM_ITEMS) begin
            repeat ($urandom_range(1, 24)) begin
                item = random_item();
                push_item(item);
                if (!(item.command == CMD_WRITE && item.coef_index >= TABLE_SIZE)) begin
                    sent++;
                end
            end
            // Receiver holds off while the sender keeps offering items.
            if (sent >= 400 && !held) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            // Sender pauses until every outstanding result has come back.
            if (sent >= 900 && !drained) begin
                idle_sender(1);
                wait_for_results();
                drained = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_sender($urandom_range(1, 12));
            end
        end
        idle_sender(1);
        wait_for_results();
        repeat (4 * ITEM_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("lqr_gain_polynomial_schedule test passed");
        end else begin
            $display("lqr_gain_polynomial_schedule test failed");
        end
        $finish;
    end

endmodule
